/* hw/rtl/qec_pkg.sv */
// shared constants, register codes and a helper for the quad element connectivity block
// no dependencies
`timescale 1ns / 1ps

package qec_pkg;

  localparam int IDX_W         = 20;
  localparam int CELLS_W       = 11;
  localparam int CORNER_W      = 21;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_MAX_CELLS = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X  = 2'd0,
    REG_CELLS_Y  = 2'd1,
    REG_PERIODIC = 2'd2
  } reg_index_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int clamp_cells(input logic [CELLS_W-1:0] v, input int max_cells);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > max_cells) begin
      r = max_cells;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/qec_div.sv */
// pipelined restoring divider, one quotient bit per stage
// splits the element index into column (remainder) and row (quotient); uses qec_pkg
`timescale 1ns / 1ps

module qec_div #(
  parameter int CW = 11,
  parameter int QW = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CW-1:0]             nx,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qec_pkg::IDX_W-1:0] in_idx,
  input  logic                      in_bad,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CW-1:0]             out_rem,
  output logic [QW-1:0]             out_quo,
  output logic                      out_bad
);
  import qec_pkg::*;

  logic          v      [QW];
  logic [CW-1:0] rem    [QW];
  logic [QW-1:0] quo    [QW];
  logic [QW-1:0] low    [QW];
  logic          bad    [QW];
  logic          en     [QW];

  logic          v_in   [QW];
  logic [CW-1:0] rem_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [QW-1:0] low_in [QW];
  logic          bad_in [QW];
  logic [CW:0]   t      [QW];
  logic [CW:0]   diff   [QW];
  logic          ge     [QW];

  // stage inputs and one compare-subtract step per stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        v_in[k]   = in_valid;
        rem_in[k] = CW'(in_idx >> QW);
        quo_in[k] = '0;
        low_in[k] = in_idx[QW-1:0];
        bad_in[k] = in_bad;
      end else begin
        v_in[k]   = v[k-1];
        rem_in[k] = rem[k-1];
        quo_in[k] = quo[k-1];
        low_in[k] = low[k-1];
        bad_in[k] = bad[k-1];
      end
      t[k]    = {rem_in[k], low_in[k][QW-1]};
      diff[k] = t[k] - {1'b0, nx};
      ge[k]   = (t[k] >= {1'b0, nx});
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    for (int k = QW - 1; k >= 0; k--) begin
      if (k == QW - 1) begin
        en[k] = !v[k] || out_ready;
      end else begin
        en[k] = !v[k] || en[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in[k];
      end
      if (en[k]) begin
        rem[k] <= ge[k] ? diff[k][CW-1:0] : t[k][CW-1:0];
        quo[k] <= (quo_in[k] << 1) | QW'(ge[k]);
        low[k] <= low_in[k] << 1;
        bad[k] <= bad_in[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[QW-1];
  assign out_rem   = rem[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_bad   = bad[QW-1];

endmodule

/* hw/rtl/qec_corner.sv */
// corner node index stages: row offsets by multiply, then the four corner sums
// holds the output register; uses qec_pkg
`timescale 1ns / 1ps

module qec_corner #(
  parameter int CW = 11,
  parameter int QW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CW-1:0]                nx,
  input  logic [CW-1:0]                ny,
  input  logic                         periodic,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CW-1:0]                in_col,
  input  logic [QW-1:0]                in_row,
  input  logic                         in_bad,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qec_pkg::CORNER_W-1:0] lower_left,
  output logic [qec_pkg::CORNER_W-1:0] lower_right,
  output logic [qec_pkg::CORNER_W-1:0] upper_right,
  output logic [qec_pkg::CORNER_W-1:0] upper_left,
  output logic                         out_bad
);
  import qec_pkg::*;

  localparam int PW = QW + CW + 2;
  localparam int SW = (PW + 1 > CORNER_W) ? PW + 1 : CORNER_W;
  localparam int EW = (QW > CW) ? QW + 1 : CW + 1;

  logic [CW:0]     pitch;
  logic [QW:0]     row_up;
  logic [QW:0]     row_next;
  logic [CW:0]     col_up;
  logic [CW:0]     col_next;
  logic [PW-1:0]   row0_next;
  logic [PW-1:0]   row1_next;

  logic            m_valid;
  logic [PW-1:0]   row0;
  logic [PW-1:0]   row1;
  logic [CW:0]     col0;
  logic [CW:0]     col1;
  logic            m_bad;
  logic            m_en;
  logic            o_en;

  logic [SW-1:0]   sum_ll;
  logic [SW-1:0]   sum_lr;
  logic [SW-1:0]   sum_ur;
  logic [SW-1:0]   sum_ul;

  // neighbor row and column, wrapped in periodic mode
  always_comb begin
    row_up = {1'b0, in_row} + (QW+1)'(1);
    col_up = {1'b0, in_col} + (CW+1)'(1);
    if (periodic) begin
      pitch    = {1'b0, nx};
      row_next = (EW'(row_up) >= EW'(ny)) ? '0 : row_up;
      col_next = (col_up == {1'b0, nx}) ? '0 : col_up;
    end else begin
      pitch    = {1'b0, nx} + (CW+1)'(1);
      row_next = row_up;
      col_next = col_up;
    end
    row0_next = PW'({1'b0, in_row}) * PW'(pitch);
    row1_next = PW'(row_next) * PW'(pitch);
  end

  assign o_en     = !out_valid || out_ready;
  assign m_en     = !m_valid || o_en;
  assign in_ready = m_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_en) begin
      m_valid <= in_valid;
    end
    if (m_en) begin
      row0  <= row0_next;
      row1  <= row1_next;
      col0  <= {1'b0, in_col};
      col1  <= col_next;
      m_bad <= in_bad;
    end
  end

  assign sum_ll = SW'(row0) + SW'(col0);
  assign sum_lr = SW'(row0) + SW'(col1);
  assign sum_ur = SW'(row1) + SW'(col1);
  assign sum_ul = SW'(row1) + SW'(col0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_en) begin
      out_valid <= m_valid;
    end
    if (o_en) begin
      lower_left  <= m_bad ? '0 : sum_ll[CORNER_W-1:0];
      lower_right <= m_bad ? '0 : sum_lr[CORNER_W-1:0];
      upper_right <= m_bad ? '0 : sum_ur[CORNER_W-1:0];
      upper_left  <= m_bad ? '0 : sum_ul[CORNER_W-1:0];
      out_bad     <= m_bad;
    end
  end

endmodule

/* hw/rtl/quad_element_connectivity.sv */
// path: entry register, divider stages, corner row-offset register, output register
// throughput: one element per cycle while corner_stall is low; the divider has one stage per quotient bit
// a stalled result holds the output register, bubbles ahead of it still fill
// reset (rst, synchronous): pipeline empty, cells_x = cells_y = 1, periodic_mode = 0
// depends on qec_pkg, qec_div, qec_corner
`timescale 1ns / 1ps

module quad_element_connectivity #(
  parameter int MAX_CELLS = qec_pkg::DEF_MAX_CELLS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qec_pkg::CELLS_W-1:0]    cfg_data,
  input  logic                           element_valid,
  output logic                           element_stall,
  input  logic [qec_pkg::IDX_W-1:0]      element_index,
  output logic                           corner_valid,
  input  logic                           corner_stall,
  output logic [qec_pkg::CORNER_W-1:0]   corner_lower_left,
  output logic [qec_pkg::CORNER_W-1:0]   corner_lower_right,
  output logic [qec_pkg::CORNER_W-1:0]   corner_upper_right,
  output logic [qec_pkg::CORNER_W-1:0]   corner_upper_left,
  output logic                           index_out_of_range
);
  import qec_pkg::*;

  localparam int CW   = $clog2(MAX_CELLS + 1);
  localparam int QW   = $clog2(MAX_CELLS);
  localparam int TW   = 2 * CW;
  localparam int CMPW = (TW > IDX_W) ? TW : IDX_W;

  logic [CW-1:0]    cells_x;
  logic [CW-1:0]    cells_y;
  logic             periodic_mode;

  logic             a_valid;
  logic [IDX_W-1:0] a_idx;
  logic [TW-1:0]    a_total;
  logic             a_en;
  logic             a_bad;

  logic             div_ready;
  logic             d_valid;
  logic             d_ready;
  logic [CW-1:0]    d_col;
  logic [QW-1:0]    d_row;
  logic             d_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x       <= CW'(1);
      cells_y       <= CW'(1);
      periodic_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_X:  cells_x       <= CW'(clamp_cells(cfg_data, MAX_CELLS));
        REG_CELLS_Y:  cells_y       <= CW'(clamp_cells(cfg_data, MAX_CELLS));
        REG_PERIODIC: periodic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // entry stage: capture index and element count
  assign a_en          = !a_valid || div_ready;
  assign element_stall = !a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= element_valid;
    end
    if (a_en) begin
      a_idx   <= element_index;
      a_total <= TW'(cells_x) * TW'(cells_y);
    end
  end

  assign a_bad = (CMPW'(a_idx) >= CMPW'(a_total));

  qec_div #(
    .CW (CW),
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .nx        (cells_x),
    .in_valid  (a_valid),
    .in_ready  (div_ready),
    .in_idx    (a_idx),
    .in_bad    (a_bad),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_rem   (d_col),
    .out_quo   (d_row),
    .out_bad   (d_bad)
  );

  qec_corner #(
    .CW (CW),
    .QW (QW)
  ) u_corner (
    .clk         (clk),
    .rst         (rst),
    .nx          (cells_x),
    .ny          (cells_y),
    .periodic    (periodic_mode),
    .in_valid    (d_valid),
    .in_ready    (d_ready),
    .in_col      (d_col),
    .in_row      (d_row),
    .in_bad      (d_bad),
    .out_valid   (corner_valid),
    .out_ready   (!corner_stall),
    .lower_left  (corner_lower_left),
    .lower_right (corner_lower_right),
    .upper_right (corner_upper_right),
    .upper_left  (corner_upper_left),
    .out_bad     (index_out_of_range)
  );

endmodule

/* hw/rtl/qec_checker.sv */
// port-level checks for quad_element_connectivity, attached by bind
// depends on qec_pkg and the top level's ports
`timescale 1ns / 1ps

module qec_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [qec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [qec_pkg::CELLS_W-1:0]    cfg_data,
  input logic                           corner_valid,
  input logic                           corner_stall,
  input logic [qec_pkg::CORNER_W-1:0]   corner_lower_left,
  input logic [qec_pkg::CORNER_W-1:0]   corner_lower_right,
  input logic [qec_pkg::CORNER_W-1:0]   corner_upper_right,
  input logic [qec_pkg::CORNER_W-1:0]   corner_upper_left,
  input logic                           index_out_of_range
);
  import qec_pkg::*;

  logic periodic;

  // mirror of the wrap mode from config transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      periodic <= 1'b0;
    end else if (cfg_valid && cfg_ready && (cfg_index == REG_PERIODIC)) begin
      periodic <= cfg_data[0];
    end
  end

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !corner_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_stall |=> corner_valid && $stable(corner_lower_left)
      && $stable(corner_upper_right) && $stable(index_out_of_range))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    corner_valid && index_out_of_range |-> (corner_lower_left == '0)
      && (corner_lower_right == '0) && (corner_upper_right == '0)
      && (corner_upper_left == '0))
    else $error("out of range result has nonzero corners");

  a_normal_adjacent: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !index_out_of_range && !periodic |->
      (corner_lower_right == CORNER_W'(corner_lower_left + CORNER_W'(1)))
      && (corner_upper_right == CORNER_W'(corner_upper_left + CORNER_W'(1))))
    else $error("normal grid corners not adjacent along x");

endmodule

bind quad_element_connectivity qec_checker u_qec_checker (.*);
